// ----- rtl/core/dccs_pkg.sv -----
// ----------------------------------------------------------------------------
// dccs_pkg
// Shared field widths, codes and constants of the distinct code statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package dccs_pkg;

    localparam int CODE_W      = 16;
    localparam int LANG_CFG_W  = 5;
    localparam int MEAN_W      = 21;
    localparam int VAR_W       = 23;
    localparam int SPREAD_W    = 6;
    localparam int FRAC_BITS   = 16;

    localparam int IN_TDATA_W  = ((CODE_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = MEAN_W + VAR_W + SPREAD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CODE_W-1:0]     MISSING_CODE = 16'hFFFF;
    localparam logic [LANG_CFG_W-1:0] LANG_RESET   = 5'd8;

endpackage : dccs_pkg

`default_nettype wire

// ----- rtl/core/distinct_code_count_statistics.sv -----
// ----------------------------------------------------------------------------
// distinct_code_count_statistics
// Per-column distinct code counts with mean, variance and range per set.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one request per language code. tdata = code (signed 16 bit),
//   tlast = end of column, tuser = end of set (also closes the column).
//   m_* stream: one request per set. tdata = mean_q16, variance_q16, spread;
//   tuser = no_complete_column.
//   cfg_*: writes language_count (5 bits); taken only between requests, ahead of s_*.
// Processing:
//   A missing code (-1) skips the scan. Any other code is compared, by
//   magnitude, against the distinct codes already held for the column (at most
//   MAX_LANGUAGES); the scan reads one stored code per cycle from the column
//   memory, which has a single read port, and stops at the first match.
//   An item that ends the set then runs the two serial divisions, mean and
//   variance, each producing DIV_NW quotient bits (DIV_NW = 2*clog2(MAX_COLUMNS+1)
//   + 2*clog2(MAX_LANGUAGES+1) + 16).
// Reset clears all totals and loads language_count = 8; the column memory
//   needs no clearing. The output register holds a result until taken; a new
//   set keeps running meanwhile and waits only when its own result is ready
//   while the previous one is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_code_count_statistics #(
    parameter int MAX_LANGUAGES = 16,
    parameter int MAX_COLUMNS   = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [dccs_pkg::IN_TDATA_W-1:0]    s_tdata,  // [15:0] code
    input  wire logic                               s_tlast,  // column_end
    input  wire logic                               s_tuser,  // set_end

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [20:0] mean_q16, [43:21] variance_q16, [49:44] spread, [55:50] zero
    output logic      [dccs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                    m_tuser,  // no_complete_column

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dccs_pkg::LANG_CFG_W-1:0]    cfg_data
);

    localparam int LW     = $clog2(MAX_LANGUAGES + 1);
    localparam int IW     = $clog2(MAX_LANGUAGES);
    localparam int CW     = $clog2(MAX_COLUMNS + 1);
    localparam int MW     = (LW > dccs_pkg::LANG_CFG_W) ? LW : dccs_pkg::LANG_CFG_W;
    localparam int SW     = LW + CW;
    localparam int CSQ_W  = 2 * LW;
    localparam int QW     = 2 * LW + CW;
    localparam int PW     = 2 * CW + 2 * LW;
    localparam int DIV_NW = PW + dccs_pkg::FRAC_BITS;
    localparam int DIV_DW = 2 * CW;
    localparam int SPW    = MW + 1;
    localparam int CODE_W = dccs_pkg::CODE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_MULT,
        ST_SUBTR,
        ST_MEAN_WAIT,
        ST_VAR_WAIT,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // column memory
    logic [CODE_W-1:0] seen_mem [MAX_LANGUAGES];
    logic [CODE_W-1:0] mem_q_reg;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;

    // item in flight
    logic [CODE_W-1:0] mag_reg;
    logic              miss_reg;
    logic              col_end_reg;
    logic              set_end_reg;
    logic [LW-1:0]     issue_reg;
    logic              pend_reg;
    logic              hit_reg;

    // column and set state
    logic [LW-1:0]     used_reg;
    logic              has_miss_reg;
    logic [CW-1:0]     cols_reg;
    logic [SW-1:0]     sum_reg;
    logic [QW-1:0]     sumsq_reg;
    logic [MW-1:0]     min_reg;
    logic [LW-1:0]     max_reg;
    logic [dccs_pkg::LANG_CFG_W-1:0] lang_reg;

    // statistics pipeline
    logic [PW-1:0]     num_reg;
    logic [PW-1:0]     sq_reg;
    logic [DIV_DW-1:0] nn_reg;
    logic [PW-1:0]     diff_reg;
    logic [dccs_pkg::MEAN_W-1:0] mean_res_reg;
    logic [dccs_pkg::VAR_W-1:0]  var_res_reg;

    // output register
    logic                                m_tvalid_reg;
    logic [dccs_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;
    logic                                m_tuser_reg;

    // divider
    logic              div_start;
    logic              div_done;
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_DW-1:0] div_divisor;
    logic [DIV_NW-1:0] div_quot;

    // input decode
    logic [CODE_W-1:0] in_code;
    logic [CODE_W-1:0] in_mag;
    logic              in_accept;

    assign in_code   = s_tdata[CODE_W-1:0];
    assign in_mag    = in_code[CODE_W-1] ? (~in_code + 1'b1) : in_code;
    assign in_accept = s_tvalid && s_tready;

    // scan control
    logic scan_issue;
    logic hit_now;
    logic scan_done;

    assign scan_issue = (state_reg == ST_SCAN) && (issue_reg < used_reg) && !hit_reg;
    assign hit_now    = pend_reg && (mem_q_reg == mag_reg);
    assign scan_done  = hit_now || hit_reg || ((issue_reg == used_reg) && !pend_reg);
    assign rd_addr    = issue_reg[IW-1:0];

    // commit and column close
    logic              full;
    logic [LW-1:0]     used_new;
    logic              miss_new;
    logic              col_ok;
    logic [CSQ_W-1:0]  c_sq;

    assign full     = (used_reg == LW'(MAX_LANGUAGES));
    assign mem_we   = (state_reg == ST_COMMIT) && !miss_reg && !hit_reg && !full;
    assign used_new = used_reg + LW'(mem_we);
    assign miss_new = has_miss_reg || miss_reg;
    assign col_ok   = !miss_new && (used_new != '0) && (cols_reg < CW'(MAX_COLUMNS));
    assign c_sq     = CSQ_W'(used_new) * CSQ_W'(used_new);

    // set statistics
    logic            set_empty;
    logic [SPW-1:0]  spread_full;

    assign set_empty   = (cols_reg == '0);
    assign spread_full = SPW'(max_reg) - SPW'(min_reg);

    assign div_start    = (state_reg == ST_SUBTR) || ((state_reg == ST_MEAN_WAIT) && div_done);
    assign div_dividend = (state_reg == ST_SUBTR)
                        ? DIV_NW'({sum_reg, {dccs_pkg::FRAC_BITS{1'b0}}})
                        : {diff_reg, {dccs_pkg::FRAC_BITS{1'b0}}};
    assign div_divisor  = (state_reg == ST_SUBTR) ? DIV_DW'(cols_reg) : nn_reg;

    dccs_div #(
        .NUM_W (DIV_NW),
        .DEN_W (DIV_DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[used_reg[IW-1:0]] <= mag_reg;
        end
        mem_q_reg <= seen_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mag_reg     <= in_mag;
            miss_reg    <= (in_code == dccs_pkg::MISSING_CODE);
            col_end_reg <= s_tlast || s_tuser;
            set_end_reg <= s_tuser;
        end
        if (state_reg == ST_MULT)
        begin
            num_reg <= PW'(cols_reg) * PW'(sumsq_reg);
            sq_reg  <= PW'(sum_reg) * PW'(sum_reg);
            nn_reg  <= DIV_DW'(cols_reg) * DIV_DW'(cols_reg);
        end
        if (state_reg == ST_SUBTR)
        begin
            diff_reg <= (num_reg > sq_reg) ? (num_reg - sq_reg) : '0;
        end
        if ((state_reg == ST_MEAN_WAIT) && div_done)
        begin
            mean_res_reg <= dccs_pkg::MEAN_W'(div_quot);
        end
        if ((state_reg == ST_VAR_WAIT) && div_done)
        begin
            var_res_reg <= dccs_pkg::VAR_W'(div_quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            used_reg     <= '0;
            has_miss_reg <= 1'b0;
            cols_reg     <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            min_reg      <= MW'(dccs_pkg::LANG_RESET);
            max_reg      <= '0;
            lang_reg     <= dccs_pkg::LANG_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (m_tready && (state_reg != ST_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                lang_reg <= cfg_data;
                if (set_empty)
                begin
                    min_reg <= MW'(cfg_data);
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        hit_reg   <= 1'b0;
                        state_reg <= (in_code == dccs_pkg::MISSING_CODE) ? ST_COMMIT : ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    pend_reg <= scan_issue;
                    if (scan_issue)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (hit_now)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_COMMIT;
                    end
                end

                ST_COMMIT:
                begin
                    if (col_end_reg)
                    begin
                        used_reg     <= '0;
                        has_miss_reg <= 1'b0;
                        if (col_ok)
                        begin
                            cols_reg  <= cols_reg + 1'b1;
                            sum_reg   <= sum_reg + SW'(used_new);
                            sumsq_reg <= sumsq_reg + QW'(c_sq);
                            if (min_reg > MW'(used_new))
                            begin
                                min_reg <= MW'(used_new);
                            end
                            if (max_reg < used_new)
                            begin
                                max_reg <= used_new;
                            end
                        end
                    end
                    else
                    begin
                        used_reg     <= used_new;
                        has_miss_reg <= miss_new;
                    end
                    state_reg <= set_end_reg ? ST_MULT : ST_IDLE;
                end

                ST_MULT:
                begin
                    state_reg <= ST_SUBTR;
                end

                ST_SUBTR:
                begin
                    state_reg <= ST_MEAN_WAIT;
                end

                ST_MEAN_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_VAR_WAIT;
                    end
                end

                ST_VAR_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_RESULT;
                    end
                end

                ST_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= dccs_pkg::OUT_TDATA_W'({
                            spread_full[dccs_pkg::SPREAD_W-1:0],
                            set_empty ? '0 : var_res_reg,
                            set_empty ? '0 : mean_res_reg});
                        m_tuser_reg  <= set_empty;
                        // start the next set
                        cols_reg     <= '0;
                        sum_reg      <= '0;
                        sumsq_reg    <= '0;
                        min_reg      <= MW'(lang_reg);
                        max_reg      <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule : distinct_code_count_statistics

`default_nettype wire

// ----- rtl/core/dccs_div.sv -----
// ----------------------------------------------------------------------------
// dccs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dccs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 22
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic             take;
    logic [DEN_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign take    = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shifted-out dividend bits make room for quotient bits
            num_reg <= {num_reg[NUM_W-2:0], take};
            rem_reg <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule : dccs_div

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for distinct_code_count_statistics. Drives code streams
// (well-formed sets, broken runs, full and overflowing columns) and compares
// each per-set statistics result with an in-bench prediction of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LANG       = 16;
    localparam int MAX_COLS       = 1024;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLD_OFF       = 150;   // covers the worst item and the set divisions
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {COL_POOL, COL_FULL, COL_DISTINCT} col_mode_t;

    typedef struct packed {
        logic [dccs_pkg::MEAN_W-1:0]   mean;
        logic [dccs_pkg::VAR_W-1:0]    variance;
        logic [dccs_pkg::SPREAD_W-1:0] spread;
        logic                          no_complete;
    } set_stats_t;

    // ------------------------------------------------------------------------
    // predictor of the per-set statistics and store of pending results
    // ------------------------------------------------------------------------
    class stats_scoreboard;
        logic [dccs_pkg::LANG_CFG_W-1:0] language_count;
        logic [16:0]           seen_mag [MAX_LANG];
        int unsigned           seen_used;
        bit                    column_missing;
        longint unsigned       n_cols;
        longint unsigned       count_sum;
        longint unsigned       count_sq_sum;
        int unsigned           min_count;
        int unsigned           max_count;
        set_stats_t            pending_stats [$];
        int unsigned           mismatches;
        int unsigned           results_checked;

        function new();
            language_count  = dccs_pkg::LANG_RESET;
            seen_used       = 0;
            column_missing  = 0;
            mismatches      = 0;
            results_checked = 0;
            clear_set();
        endfunction

        function void clear_set();
            n_cols       = 0;
            count_sum    = 0;
            count_sq_sum = 0;
            min_count    = language_count;
            max_count    = 0;
        endfunction

        function void write_language_count(input logic [dccs_pkg::LANG_CFG_W-1:0] value);
            language_count = value;
            if (n_cols == 0)
                min_count = value;
        endfunction

        function int unsigned pending();
            return pending_stats.size();
        endfunction

        function void note_request(input logic [dccs_pkg::CODE_W-1:0] code, input bit last,
                                   input bit set_end);
            logic [16:0]     mag;
            bit              found;
            set_stats_t      want;
            longint unsigned num;
            longint unsigned sq;
            if (code == dccs_pkg::MISSING_CODE)
            begin
                column_missing = 1;
            end
            else
            begin
                mag   = code[dccs_pkg::CODE_W-1] ? (17'h10000 - {1'b0, code}) : {1'b0, code};
                found = 0;
                for (int i = 0; i < seen_used; i++)
                    if (seen_mag[i] == mag)
                        found = 1;
                // full store drops new magnitudes
                if (!found && seen_used < MAX_LANG)
                begin
                    seen_mag[seen_used] = mag;
                    seen_used++;
                end
            end
            if (last || set_end)
            begin
                if (!column_missing && seen_used > 0 && n_cols < MAX_COLS)
                begin
                    n_cols++;
                    count_sum    += seen_used;
                    count_sq_sum += seen_used * seen_used;
                    if (min_count > seen_used)
                        min_count = seen_used;
                    if (max_count < seen_used)
                        max_count = seen_used;
                end
                seen_used      = 0;
                column_missing = 0;
            end
            if (set_end)
            begin
                want = '0;
                if (n_cols > 0)
                begin
                    num           = n_cols * count_sq_sum;
                    sq            = count_sum * count_sum;
                    want.mean     = dccs_pkg::MEAN_W'((count_sum << dccs_pkg::FRAC_BITS)
                                                      / n_cols);
                    want.variance = (num > sq) ?
                                    dccs_pkg::VAR_W'(((num - sq) << dccs_pkg::FRAC_BITS)
                                                     / (n_cols * n_cols)) : '0;
                end
                want.spread      = dccs_pkg::SPREAD_W'(max_count - min_count);
                want.no_complete = (n_cols == 0);
                pending_stats.insert(pending_stats.size(), want);
                clear_set();
            end
        endfunction

        function void check_result(input logic [dccs_pkg::OUT_TDATA_W-1:0] tdata,
                                   input logic tuser);
            set_stats_t got;
            set_stats_t want;
            logic [dccs_pkg::OUT_TDATA_W-dccs_pkg::OUT_FIELD_W-1:0] pad;
            got.mean        = tdata[dccs_pkg::MEAN_W-1:0];
            got.variance    = tdata[dccs_pkg::MEAN_W +: dccs_pkg::VAR_W];
            got.spread      = tdata[dccs_pkg::MEAN_W+dccs_pkg::VAR_W +: dccs_pkg::SPREAD_W];
            got.no_complete = tuser;
            pad             = tdata[dccs_pkg::OUT_TDATA_W-1:dccs_pkg::OUT_FIELD_W];
            results_checked++;
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: mean=%0d var=%0d spread=%0d none=%0b",
                             $realtime, got.mean, got.variance, $signed(got.spread),
                             got.no_complete);
                return;
            end
            want = pending_stats.pop_front();
            if (got !== want || pad !== '0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] result mismatch: exp mean=%0d var=%0d spread=%0d ",
                              "none=%0b, got mean=%0d var=%0d spread=%0d none=%0b pad=%0h"},
                             $realtime, want.mean, want.variance, $signed(want.spread),
                             want.no_complete, got.mean, got.variance,
                             $signed(got.spread), got.no_complete, pad);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [dccs_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [dccs_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dccs_pkg::LANG_CFG_W-1:0]  cfg_data  = '0;

    stats_scoreboard sb;
    int unsigned     idle_pct      = 28;
    int unsigned     requests_sent = 0;
    int unsigned     cfg_writes    = 0;

    distinct_code_count_statistics #(
        .MAX_LANGUAGES (MAX_LANG),
        .MAX_COLUMNS   (MAX_COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: random back-pressure, check on every taken result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    initial
    begin
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("distinct_code_count_statistics regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [dccs_pkg::CODE_W-1:0] code, input bit last,
                                input bit set_end);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= last;
        s_tuser  <= set_end;
        do @(posedge clk); while (!s_tready);
        sb.note_request(code, last, set_end);
        requests_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_language_count(input logic [dccs_pkg::LANG_CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_language_count(value);
        cfg_writes++;
    endtask

    // small magnitudes with both signs, so duplicates by magnitude are common
    function automatic logic [dccs_pkg::CODE_W-1:0] pool_code();
        logic [dccs_pkg::CODE_W-1:0] mag;
        logic [dccs_pkg::CODE_W-1:0] code;
        mag  = dccs_pkg::CODE_W'($urandom_range(0, 9));
        code = $urandom_range(0, 1) ? -mag : mag;
        if (code == dccs_pkg::MISSING_CODE)
            code = 16'd1;
        return code;
    endfunction

    task automatic send_column(input int len, input col_mode_t mode, input int miss_pct,
                               input bit set_end, input bit last_flag);
        logic [dccs_pkg::CODE_W-1:0] code;
        logic [dccs_pkg::CODE_W-1:0] mag;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                COL_FULL: code = dccs_pkg::CODE_W'($urandom);
                COL_DISTINCT:
                begin
                    // low bits keep magnitudes unique within the column
                    mag  = dccs_pkg::CODE_W'(($urandom_range(0, 1023) << 5) | (i + 2));
                    code = $urandom_range(0, 1) ? -mag : mag;
                end
                default: code = pool_code();
            endcase
            if ($urandom_range(0, 99) < miss_pct)
                code = dccs_pkg::MISSING_CODE;
            if (i == len - 1)
                send_request(code, last_flag, set_end);
            else
                send_request(code, 1'b0, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned random_base;
        int unsigned sets_done;
        int unsigned ncols;
        int unsigned len;
        int unsigned pick;
        col_mode_t   mode;
        int          miss_pct;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the code, -32768 magnitude, sign-only duplicates
        send_request(16'h7FFF, 1'b0, 1'b0);
        send_request(16'h8000, 1'b0, 1'b0);
        send_request(16'h0000, 1'b0, 1'b0);
        send_request(16'h7FFF, 1'b0, 1'b0);
        send_request(16'hFFFB, 1'b0, 1'b0);
        send_request(16'h0005, 1'b1, 1'b0);
        // write while the set already holds a complete column
        drain();
        repeat (HOLD_OFF) @(posedge clk);
        write_language_count(5'd16);
        // column with a missing code, closed by set end alone
        send_request(16'h0003, 1'b0, 1'b0);
        send_request(dccs_pkg::MISSING_CODE, 1'b0, 1'b1);
        // empty set
        send_request(dccs_pkg::MISSING_CODE, 1'b1, 1'b1);
        drain();
        repeat (HOLD_OFF) @(posedge clk);
        write_language_count(5'd1);
        // more distinct magnitudes than the store holds
        send_column(17, COL_DISTINCT, 0, 1'b1, 1'b1);

        // column count overflow: one-code columns past the column limit
        for (int i = 0; i < MAX_COLS + 6; i++)
            send_request(pool_code(), 1'b1, i == MAX_COLS + 5);
        drain();
        repeat (HOLD_OFF) @(posedge clk);
        write_language_count(5'd8);

        random_base = requests_sent;
        sets_done   = 0;
        while (requests_sent - random_base < RANDOM_ITEMS)
        begin
            sets_done++;
            idle_pct = (requests_sent - random_base >= 400 &&
                        requests_sent - random_base < 700) ? 0 : 28;
            if (sets_done % 20 == 0)
            begin
                drain();
                repeat (HOLD_OFF) @(posedge clk);
                case ((sets_done / 20) % 4)
                    0:       write_language_count(5'd1);
                    1:       write_language_count(5'd16);
                    default: write_language_count(
                                 dccs_pkg::LANG_CFG_W'($urandom_range(1, 16)));
                endcase
            end
            if ($urandom_range(0, 99) < 8)
            begin
                // broken run: flags at random, may stop mid-column
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_request(($urandom_range(0, 99) < 20) ? dccs_pkg::MISSING_CODE :
                                 ($urandom_range(0, 1) ? pool_code() :
                                  dccs_pkg::CODE_W'($urandom)),
                                 $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 10);
            end
            else
            begin
                ncols = $urandom_range(1, 6);
                for (int c = 0; c < ncols; c++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 6)
                    begin
                        mode = COL_DISTINCT;
                        len  = $urandom_range(15, 20);
                    end
                    else if (pick < 30)
                    begin
                        mode = COL_FULL;
                        len  = $urandom_range(1, 8);
                    end
                    else
                    begin
                        mode = COL_POOL;
                        len  = $urandom_range(1, 10);
                    end
                    miss_pct = ($urandom_range(0, 3) == 0) ? 15 : 0;
                    send_column(len, mode, miss_pct, c == ncols - 1,
                                (c == ncols - 1) ? bit'($urandom_range(0, 1)) : 1'b1);
                end
            end
            if (sets_done % 15 == 7)
                drain();
        end

        drain();
        repeat (HOLD_OFF) @(posedge clk);

        $display("covered %0d code requests, %0d set results, %0d language_count writes",
                 requests_sent, sb.results_checked, cfg_writes);
        $display("incl. overflowing columns, column limit, empty sets, mid-set writes");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("distinct_code_count_statistics regression: pass");
        else
        begin
            $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
            $display("distinct_code_count_statistics regression: fail");
        end
        $finish;
    end

endmodule : tb

`default_nettype wire
